>>> sv/sioidr_pkg.sv
// Package for the Super I/O index/data resource decoder.
// Access codes, register map constants and the base address decode functions.
// No dependencies.
`default_nettype none

package sioidr_pkg;

    typedef enum logic [1:0]
    {
        FUNC_CFG_READ   = 2'd0,
        FUNC_CFG_WRITE  = 2'd1,
        FUNC_GPIO_READ  = 2'd2,
        FUNC_GPIO_WRITE = 2'd3
    } func_t;

    localparam int NUM_REGS = 32;
    localparam int IDX_W    = $clog2(NUM_REGS);

    typedef logic [7:0]       byte_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [9:0]       base_t;
    typedef logic [2:0]       irq_t;

    localparam byte_t CHIP_ID   = 8'h88;
    localparam byte_t FORCE_VAL = 8'h70;
    localparam byte_t GPIO_MASK = 8'hff;

    localparam idx_t REG_FER      = 5'h00;
    localparam idx_t REG_FAR      = 5'h01;
    localparam idx_t REG_FORCED   = 5'h08;
    localparam idx_t REG_GPIO_BA  = 5'h0f;
    localparam idx_t REG_PMC      = 5'h12;
    localparam idx_t REG_LPT_EXT  = 5'h1b;

    localparam byte_t FAR_RESET     = 8'h10;
    localparam byte_t GPIO_BA_RESET = 8'h1e;
    localparam byte_t PMC_RESET     = 8'h30;

    localparam irq_t IRQ_EVEN = 3'd4;
    localparam irq_t IRQ_ODD  = 3'd3;

    function automatic byte_t reg_reset_value(input idx_t idx);
        byte_t v;
        v = '0;
        if (idx == REG_FAR)
            v = FAR_RESET;
        else if (idx == REG_GPIO_BA)
            v = GPIO_BA_RESET;
        else if (idx == REG_PMC)
            v = PMC_RESET;
        return v;
    endfunction

    function automatic base_t serial_base(input logic [1:0] sel, input logic [1:0] hi);
        base_t b;
        b = '0;
        unique case (sel)
            2'd0: b = 10'h3f8;
            2'd1: b = 10'h2f8;
            2'd2:
            begin
                unique case (hi)
                    2'd0: b = 10'h3e8;
                    2'd1: b = 10'h338;
                    2'd2: b = 10'h2e8;
                    2'd3: b = 10'h220;
                endcase
            end
            2'd3:
            begin
                unique case (hi)
                    2'd0: b = 10'h2e8;
                    2'd1: b = 10'h238;
                    2'd2: b = 10'h2e0;
                    2'd3: b = 10'h228;
                endcase
            end
        endcase
        return b;
    endfunction

    // reserved codes 3 and 11 decode to no port
    function automatic base_t parallel_base(input logic [3:0] code);
        base_t b;
        b = '0;
        unique case (code)
            4'h0, 4'h8, 4'h4, 4'h5, 4'h6, 4'h7:   b = 10'h378;
            4'h1, 4'h9:                           b = 10'h3bc;
            4'h2, 4'ha, 4'hc, 4'hd, 4'he, 4'hf:   b = 10'h278;
            4'h3, 4'hb:                           b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/superio_index_data_resource_decoder_core.sv
// Top level of the Super I/O index/data resource decoder.
// Holds the index latch, register file, GPIO latch and the resource map decode.
// Depends on sioidr_pkg.
//
// Usage:
//   A bus access word (func, port_odd, write_data) is taken at a rising edge
//   with start high and busy low. busy is always low: a word may be issued
//   every cycle.
//   The word is registered, then executed against the register file in the
//   following cycle; its result (read_data and the full resource map) is
//   registered and shown with done high for exactly one cycle.
//   Throughput: one word per cycle, set by the single register file
//   update and the index latch in the execute cycle.
//   The map reflects the register contents after the access itself.
//   The receiver cannot stall: a result not taken in its done cycle is gone.
//   Reset (rst_n low, asynchronous) clears the pipeline, loads the register
//   file defaults, zeroes the index and GPIO latches and arms the chip
//   identity read. It takes effect at once; no clearing pass follows.
`default_nettype none

module superio_index_data_resource_decoder_core
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  [1:0]           func,
    input  wire                  port_odd,
    input  wire  [7:0]           write_data,
    output logic                 done,
    output sioidr_pkg::byte_t    read_data,
    output logic                 fdc_enabled,
    output logic                 com1_enabled,
    output sioidr_pkg::base_t    com1_base,
    output sioidr_pkg::irq_t     com1_irq,
    output logic                 com2_enabled,
    output sioidr_pkg::base_t    com2_base,
    output sioidr_pkg::irq_t     com2_irq,
    output sioidr_pkg::base_t    lpt_base,
    output sioidr_pkg::base_t    gpio_base
);

    import sioidr_pkg::*;

    logic  valid_reg;
    func_t func_reg;
    logic  odd_reg;
    byte_t wd_reg;

    byte_t cfg_reg  [NUM_REGS];
    byte_t cfg_next [NUM_REGS];
    idx_t  index_reg, index_next;
    logic  id_pending_reg, id_pending_next;
    byte_t gpio_reg, gpio_next;

    logic  done_reg;
    byte_t rd_reg, rd_next;
    logic  fdc_reg, fdc_next;
    logic  c1en_reg, c1en_next;
    base_t c1base_reg, c1base_next;
    irq_t  c1irq_reg, c1irq_next;
    logic  c2en_reg, c2en_next;
    base_t c2base_reg, c2base_next;
    irq_t  c2irq_reg, c2irq_next;
    base_t lpt_reg, lpt_next;
    base_t gba_reg, gba_next;

    byte_t fer, far_v, ext;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func_t'(func);
            odd_reg  <= port_odd;
            wd_reg   <= write_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
            cfg_next[i] = cfg_reg[i];
        index_next      = index_reg;
        id_pending_next = id_pending_reg;
        gpio_next       = gpio_reg;
        rd_next         = '0;
        if (valid_reg)
        begin
            unique case (func_reg)
                FUNC_CFG_READ:
                begin
                    if (!odd_reg)
                    begin
                        if (id_pending_reg)
                        begin
                            id_pending_next = 1'b0;
                            rd_next         = CHIP_ID;
                        end
                        else
                        begin
                            rd_next = byte_t'(index_reg);
                        end
                    end
                    else
                    begin
                        cfg_next[REG_FORCED] = FORCE_VAL;
                        rd_next = (index_reg == REG_FORCED) ? FORCE_VAL : cfg_reg[index_reg];
                    end
                end
                FUNC_CFG_WRITE:
                begin
                    if (!odd_reg)
                        index_next = wd_reg[IDX_W-1:0];
                    else
                        cfg_next[index_reg] = wd_reg;
                end
                FUNC_GPIO_READ:
                begin
                    rd_next = odd_reg ? GPIO_MASK : gpio_reg;
                end
                FUNC_GPIO_WRITE:
                begin
                    if (!odd_reg)
                        gpio_next = wd_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        fer   = cfg_next[REG_FER];
        far_v = cfg_next[REG_FAR];
        ext   = cfg_next[REG_LPT_EXT];

        fdc_next    = fer[3];
        c1en_next   = fer[1];
        c2en_next   = fer[2];
        c1base_next = fer[1] ? serial_base(far_v[3:2], far_v[7:6]) : '0;
        c1irq_next  = fer[1] ? (far_v[2] ? IRQ_ODD : IRQ_EVEN) : '0;
        c2base_next = fer[2] ? serial_base(far_v[5:4], far_v[7:6]) : '0;
        c2irq_next  = fer[2] ? (far_v[4] ? IRQ_ODD : IRQ_EVEN) : '0;
        lpt_next    = fer[0] ? parallel_base({ext[5:4], far_v[1:0]}) : '0;
        gba_next    = {cfg_next[REG_GPIO_BA], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= reg_reset_value(idx_t'(i));
            index_reg      <= '0;
            id_pending_reg <= 1'b1;
            gpio_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= cfg_next[i];
            index_reg      <= index_next;
            id_pending_reg <= id_pending_next;
            gpio_reg       <= gpio_next;
            done_reg       <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            rd_reg     <= rd_next;
            fdc_reg    <= fdc_next;
            c1en_reg   <= c1en_next;
            c1base_reg <= c1base_next;
            c1irq_reg  <= c1irq_next;
            c2en_reg   <= c2en_next;
            c2base_reg <= c2base_next;
            c2irq_reg  <= c2irq_next;
            lpt_reg    <= lpt_next;
            gba_reg    <= gba_next;
        end
    end

    assign done         = done_reg;
    assign read_data    = rd_reg;
    assign fdc_enabled  = fdc_reg;
    assign com1_enabled = c1en_reg;
    assign com1_base    = c1base_reg;
    assign com1_irq     = c1irq_reg;
    assign com2_enabled = c2en_reg;
    assign com2_base    = c2base_reg;
    assign com2_irq     = c2irq_reg;
    assign lpt_base     = lpt_reg;
    assign gpio_base    = gba_reg;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done)
        else $error("accepted word produced no result");

    a_id_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(id_pending_reg) |-> $past(valid_reg && func_reg == FUNC_CFG_READ && !odd_reg))
        else $error("identity flag cleared without an index read");

    a_com1_irq: assert property (@(posedge clk) disable iff (!rst_n)
        done && !com1_enabled |-> com1_irq == '0 && com1_base == '0)
        else $error("disabled serial port reports resources");

    a_id_read: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(id_pending_reg) |-> read_data == CHIP_ID && done)
        else $error("identity read returned wrong byte");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for superio_index_data_resource_decoder_core: directed and random bus access words,
// with results checked against an in-bench predictor of the register file and resource map.
// Depends on sioidr_pkg and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sioidr_pkg::*;

    typedef struct
    {
        func_t fn;
        logic  odd;
        byte_t wd;
        bit    hold;
    } bus_word_t;

    typedef struct packed
    {
        byte_t rd;
        logic  fdc;
        logic  com1_en;
        base_t com1_b;
        irq_t  com1_i;
        logic  com2_en;
        base_t com2_b;
        irq_t  com2_i;
        base_t lpt_b;
        base_t gpio_b;
    } resmap_t;

    localparam int RANDOM_WORDS = 750;
    localparam int IDLE_LIMIT   = 500;

    // serial bases for select 2 and 3, indexed by the high bits
    localparam logic [39:0] SEL2_BASES = {10'h220, 10'h2e8, 10'h338, 10'h3e8};
    localparam logic [39:0] SEL3_BASES = {10'h228, 10'h2e0, 10'h238, 10'h2e8};
    // parallel bases by 4-bit code, code 0 in the low slice
    localparam logic [159:0] LPT_BASES =
    {
        10'h278, 10'h278, 10'h278, 10'h278, 10'h000, 10'h278, 10'h3bc, 10'h378,
        10'h378, 10'h378, 10'h378, 10'h378, 10'h000, 10'h278, 10'h3bc, 10'h378
    };

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  start      = 1'b0;
    func_t func       = FUNC_CFG_READ;
    logic  port_odd   = 1'b0;
    byte_t write_data = '0;

    logic  busy;
    logic  done;
    byte_t read_data;
    logic  fdc_enabled;
    logic  com1_enabled;
    base_t com1_base;
    irq_t  com1_irq;
    logic  com2_enabled;
    base_t com2_base;
    irq_t  com2_irq;
    base_t lpt_base;
    base_t gpio_base;

    superio_index_data_resource_decoder_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .port_odd     (port_odd),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .fdc_enabled  (fdc_enabled),
        .com1_enabled (com1_enabled),
        .com1_base    (com1_base),
        .com1_irq     (com1_irq),
        .com2_enabled (com2_enabled),
        .com2_base    (com2_base),
        .com2_irq     (com2_irq),
        .lpt_base     (lpt_base),
        .gpio_base    (gpio_base)
    );

    bus_word_t pending[$];
    resmap_t   map_due[$];

    byte_t regs_m [NUM_REGS];
    idx_t  idx_m;
    logic  id_armed;
    byte_t gpio_latch;

    int mismatches  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    bit word_taken  = 1'b0;

    always #6 clk = ~clk;

    function automatic base_t uart_base(input logic [1:0] sel, input logic [1:0] hi);
        base_t b;
        case (sel)
            2'd0:    b = 10'h3f8;
            2'd1:    b = 10'h2f8;
            2'd2:    b = SEL2_BASES[hi*10 +: 10];
            default: b = SEL3_BASES[hi*10 +: 10];
        endcase
        return b;
    endfunction

    // executes one access on the shadow state and returns the word it should produce
    function automatic resmap_t decode_access(input func_t fn, input logic odd, input byte_t wd);
        resmap_t r;
        byte_t   fer;
        byte_t   far_r;
        r = '0;
        case (fn)
            FUNC_CFG_READ:
            begin
                if (!odd)
                begin
                    if (id_armed)
                    begin
                        id_armed = 1'b0;
                        r.rd = CHIP_ID;
                    end
                    else
                        r.rd = byte_t'(idx_m);
                end
                else
                begin
                    regs_m[REG_FORCED] = FORCE_VAL;
                    r.rd = regs_m[idx_m];
                end
            end
            FUNC_CFG_WRITE:
            begin
                if (!odd)
                    idx_m = wd[IDX_W-1:0];
                else
                    regs_m[idx_m] = wd;
            end
            FUNC_GPIO_READ:
                r.rd = odd ? GPIO_MASK : gpio_latch;
            default:
            begin
                if (!odd)
                    gpio_latch = wd;
            end
        endcase
        fer   = regs_m[REG_FER];
        far_r = regs_m[REG_FAR];
        r.fdc     = fer[3];
        r.com1_en = fer[1];
        r.com2_en = fer[2];
        if (fer[1])
        begin
            r.com1_b = uart_base(far_r[3:2], far_r[7:6]);
            r.com1_i = far_r[2] ? IRQ_ODD : IRQ_EVEN;
        end
        if (fer[2])
        begin
            r.com2_b = uart_base(far_r[5:4], far_r[7:6]);
            r.com2_i = far_r[4] ? IRQ_ODD : IRQ_EVEN;
        end
        if (fer[0])
            r.lpt_b = LPT_BASES[{regs_m[REG_LPT_EXT][5:4], far_r[1:0]}*10 +: 10];
        r.gpio_b = {regs_m[REG_GPIO_BA], 2'b00};
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s wrong, expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic queue_word(input func_t fn, input logic odd, input byte_t wd, input bit hold);
        bus_word_t w;
        w.fn   = fn;
        w.odd  = odd;
        w.wd   = wd;
        w.hold = hold;
        pending.push_back(w);
    endtask

    function automatic idx_t pick_index();
        idx_t i;
        case ($urandom_range(0, 9))
            0:       i = REG_FER;
            1:       i = REG_FAR;
            2:       i = REG_GPIO_BA;
            3:       i = REG_LPT_EXT;
            4:       i = REG_FORCED;
            default: i = idx_t'($urandom_range(0, NUM_REGS-1));
        endcase
        return i;
    endfunction

    // driver: new word after the previous one is taken, in bursts with gaps
    always @(negedge clk)
    begin : drive_word
        bus_word_t w;
        logic      go;
        func_t     f_n;
        logic      o_n;
        byte_t     d_n;
        go  = start;
        f_n = func;
        o_n = port_odd;
        d_n = write_data;
        if (rst_n && (!start || word_taken))
        begin
            go  = 1'b0;
            f_n = func_t'($urandom_range(0, 3));
            o_n = 1'($urandom_range(0, 1));
            d_n = byte_t'($urandom_range(0, 255));
            if (gap_left > 0)
                gap_left--;
            else if (pending.size() > 0 && !(pending[0].hold && map_due.size() > 0))
            begin
                w   = pending.pop_front();
                go  = 1'b1;
                f_n = w.fn;
                o_n = w.odd;
                d_n = w.wd;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
        start      <= go;
        func       <= f_n;
        port_odd   <= o_n;
        write_data <= d_n;
    end

    // monitor: check results, predict accepted words, watchdog
    always @(posedge clk)
    begin : watch_bus
        resmap_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (map_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing outstanding", $realtime);
                end
                else
                begin
                    want = map_due.pop_front();
                    check_field("read_data", want.rd, read_data);
                    check_field("fdc_enabled", want.fdc, fdc_enabled);
                    check_field("com1_enabled", want.com1_en, com1_enabled);
                    check_field("com1_base", want.com1_b, com1_base);
                    check_field("com1_irq", want.com1_i, com1_irq);
                    check_field("com2_enabled", want.com2_en, com2_enabled);
                    check_field("com2_base", want.com2_b, com2_base);
                    check_field("com2_irq", want.com2_i, com2_irq);
                    check_field("lpt_base", want.lpt_b, lpt_base);
                    check_field("gpio_base", want.gpio_b, gpio_base);
                end
            end
            word_taken = start && !busy;
            if (word_taken)
                map_due.push_back(decode_access(func, port_odd, write_data));
            if (word_taken || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int    n_rand;
        int    next_drain;
        bit    hold;
        idx_t  ri;
        for (int i = 0; i < NUM_REGS; i++)
            regs_m[i] = '0;
        regs_m[REG_FAR]     = FAR_RESET;
        regs_m[REG_GPIO_BA] = GPIO_BA_RESET;
        regs_m[REG_PMC]     = PMC_RESET;
        idx_m      = '0;
        id_armed   = 1'b1;
        gpio_latch = '0;

        // directed: identity read, forced register, index masking, map decode, GPIO pair
        queue_word(FUNC_CFG_READ, 1'b0, 8'h00, 1'b0);
        queue_word(FUNC_CFG_READ, 1'b0, 8'hff, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'he8, 1'b0);
        queue_word(FUNC_CFG_READ, 1'b1, 8'h00, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'h00, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'h0f, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'h01, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'hff, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'h03, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'h1b, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'h30, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'h20, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'h0f, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'hff, 1'b0);
        queue_word(FUNC_CFG_READ, 1'b1, 8'hff, 1'b0);
        queue_word(FUNC_GPIO_WRITE, 1'b0, 8'ha5, 1'b0);
        queue_word(FUNC_GPIO_READ, 1'b0, 8'h00, 1'b0);
        queue_word(FUNC_GPIO_READ, 1'b1, 8'h00, 1'b0);
        queue_word(FUNC_GPIO_WRITE, 1'b1, 8'h5a, 1'b0);
        queue_word(FUNC_GPIO_READ, 1'b0, 8'hff, 1'b0);
        queue_word(FUNC_CFG_READ, 1'b0, 8'h00, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b0, 8'h1f, 1'b0);
        queue_word(FUNC_CFG_WRITE, 1'b1, 8'h00, 1'b0);
        queue_word(FUNC_CFG_READ, 1'b1, 8'h00, 1'b0);

        // random: mostly index-then-data sequences, some GPIO and noise
        n_rand     = 0;
        next_drain = 0;
        while (n_rand < RANDOM_WORDS)
        begin
            hold = (n_rand >= next_drain);
            if (hold)
                next_drain += 250;
            ri = pick_index();
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    queue_word(FUNC_CFG_WRITE, 1'b0, {3'($urandom_range(0, 7)), ri}, hold);
                    queue_word(FUNC_CFG_WRITE, 1'b1, byte_t'($urandom_range(0, 255)), 1'b0);
                    n_rand += 2;
                end
                4, 5:
                begin
                    queue_word(FUNC_CFG_WRITE, 1'b0, {3'($urandom_range(0, 7)), ri}, hold);
                    queue_word(FUNC_CFG_READ, 1'b1, byte_t'($urandom_range(0, 255)), 1'b0);
                    n_rand += 2;
                end
                6:
                begin
                    queue_word($urandom_range(0, 1) ? FUNC_GPIO_READ : FUNC_GPIO_WRITE,
                               1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)), hold);
                    n_rand++;
                end
                7:
                begin
                    queue_word(FUNC_CFG_READ, 1'b0, byte_t'($urandom_range(0, 255)), hold);
                    n_rand++;
                end
                8:
                begin
                    queue_word(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               byte_t'($urandom_range(0, 255)), hold);
                    n_rand++;
                end
                default:
                begin
                    queue_word($urandom_range(0, 1) ? FUNC_CFG_READ : FUNC_CFG_WRITE, 1'b1,
                               byte_t'($urandom_range(0, 255)), hold);
                    n_rand++;
                end
            endcase
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start || map_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
